// ----- sv/frlq_pkg.sv -----
// Shared types, codes and defaults for the flash ring log queue.
package frlq_pkg;

  localparam int unsigned NUM_SLOTS_DEF        = 1024;
  localparam int unsigned SLOTS_PER_SECTOR_DEF = 16;
  localparam int unsigned JOURNAL_ENTRIES_DEF  = 61;

  localparam logic [7:0] CKPT_INTERVAL_RST = 8'd64;

  // slot status codes
  localparam logic [1:0] ST_ERASED    = 2'd0;
  localparam logic [1:0] ST_PENDING   = 2'd1;
  localparam logic [1:0] ST_DELIVERED = 2'd2;

  // command codes
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_PEEK   = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;
  localparam logic [1:0] CMD_FLUSH  = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] order;
    logic [63:0] payload;
  } slot_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] payload_in;
    logic        force_checkpoint;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] payload_out;
    logic [10:0] pending_count;
    logic [31:0] dropped_total;
    logic        checkpoint_taken;
    logic [31:0] generation;
    logic        header_sector;
    logic [5:0]  header_entry;
  } out_t;

endpackage

// ----- sv/flash_ring_log_queue.sv -----
// Flash ring log queue top level: command sequencer around the slot memory.
//
// A ring of NUM_SLOTS record slots in one synchronous memory, grouped into
// erase sectors of SLOTS_PER_SECTOR. After reset a clearing pass marks every
// slot erased; input is stalled until it ends. One command is worked at a
// time. A plain append reads the head slot and writes the record there; an
// append that hits an occupied head erases the sector and rebuilds by a full
// memory scan. Peek reads the tail slot, and rebuilds by the same scan when
// a stale tail forces it. Pop marks the tail delivered and walks forward to
// find the next pending record (at most NUM_SLOTS slots). The single memory
// read port reads one slot per cycle. A result sits in an output register
// until its transfer completes; the next command is taken meanwhile.
module flash_ring_log_queue #(
  parameter int unsigned NUM_SLOTS        = frlq_pkg::NUM_SLOTS_DEF,
  parameter int unsigned SLOTS_PER_SECTOR = frlq_pkg::SLOTS_PER_SECTOR_DEF,
  parameter int unsigned JOURNAL_ENTRIES  = frlq_pkg::JOURNAL_ENTRIES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  frlq_pkg::in_t   in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output frlq_pkg::out_t  out_o,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_data_i
);
  import frlq_pkg::*;

  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  localparam int unsigned IDX_W  = SLOT_W + 1;
  localparam int unsigned CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned OFF_W  = $clog2(SLOTS_PER_SECTOR);
  localparam int unsigned K_W    = $clog2(SLOTS_PER_SECTOR + 1);
  localparam int unsigned JU_W   = $clog2(JOURNAL_ENTRIES + 1);

  // sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HEAD  = 4'd2;
  localparam logic [3:0] S_ERASE = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_RBEND = 4'd5;
  localparam logic [3:0] S_WRITE = 4'd6;
  localparam logic [3:0] S_TAIL  = 4'd7;
  localparam logic [3:0] S_ADV   = 4'd8;
  localparam logic [3:0] S_PEEK2 = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] state_q, state_d;

  // latched command
  logic [1:0]  cmd_q, cmd_d;
  logic [63:0] pay_q, pay_d;
  logic        force_q, force_d;
  logic        ok_q, ok_d;
  logic [63:0] pout_q, pout_d;
  logic        ckpt_q, ckpt_d;

  // queue state
  logic [SLOT_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [SLOT_W-1:0] hbase_q, hbase_d;
  logic [OFF_W-1:0]  hoff_q, hoff_d;
  logic [CNT_W-1:0]  pendt_q, pendt_d;
  logic [31:0]       drop_q, drop_d;
  logic [31:0]       nord_q, nord_d;
  logic [31:0]       gen_q, gen_d;
  logic [7:0]        ops_q, ops_d;
  logic              act_q, act_d;
  logic [JU_W-1:0]   ju_q, ju_d;
  logic [7:0]        intv_q;

  // scan / walk bookkeeping
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  sb_q, sb_d, psb_q, psb_d;
  logic [OFF_W-1:0]  so_q, so_d, pso_q, pso_d;
  logic [K_W-1:0]    k_q, k_d;
  logic              live_q, live_d;
  logic [SLOT_W-1:0] pidx_q, pidx_d;
  logic [SLOT_W-1:0] cur_q, cur_d;

  // rebuild accumulators
  logic              any_q, any_d, anyp_q, anyp_d;
  logic [31:0]       maxo_q, maxo_d, mino_q, mino_d;
  logic [SLOT_W-1:0] maxs_q, maxs_d, mins_q, mins_d;
  logic [SLOT_W-1:0] maxb_q, maxb_d;
  logic [OFF_W-1:0]  maxoff_q, maxoff_d;
  logic [CNT_W-1:0]  pend_q, pend_d;

  // output register
  out_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  // memory port
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr, rd_addr;
  slot_t             mem_wdata, mem_q;

  // helpers
  logic [SLOT_W-1:0] mx_nxt, mx_nb, hd_nxt, hd_nb, cur_nxt, rb_tail;
  logic [OFF_W-1:0]  mx_no, hd_no;
  logic [IDX_W-1:0]  erase_addr;
  logic [8:0]        ops_inc;
  logic              ckpt_do, start_scan, tail_pend;

  frlq_slot_ram #(
    .DEPTH (NUM_SLOTS),
    .AW    (SLOT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_addr),
    .rdata_o (mem_q)
  );

  // slot after the rebuild maximum, with its sector position
  always_comb begin
    mx_nxt = '0;
    mx_nb  = '0;
    mx_no  = '0;
    if (maxs_q != SLOT_W'(NUM_SLOTS - 1)) begin
      mx_nxt = maxs_q + SLOT_W'(1);
      if (maxoff_q == OFF_W'(SLOTS_PER_SECTOR - 1)) begin
        mx_nb = maxb_q + SLOT_W'(SLOTS_PER_SECTOR);
      end else begin
        mx_nb = maxb_q;
        mx_no = maxoff_q + OFF_W'(1);
      end
    end
  end

  // slot after the head, with its sector position
  always_comb begin
    hd_nxt = '0;
    hd_nb  = '0;
    hd_no  = '0;
    if (head_q != SLOT_W'(NUM_SLOTS - 1)) begin
      hd_nxt = head_q + SLOT_W'(1);
      if (hoff_q == OFF_W'(SLOTS_PER_SECTOR - 1)) begin
        hd_nb = hbase_q + SLOT_W'(SLOTS_PER_SECTOR);
      end else begin
        hd_nb = hbase_q;
        hd_no = hoff_q + OFF_W'(1);
      end
    end
  end

  assign cur_nxt    = (cur_q == SLOT_W'(NUM_SLOTS - 1)) ? '0 : cur_q + SLOT_W'(1);
  assign rb_tail    = (pend_q != '0) ? mins_q : mx_nxt;
  assign erase_addr = {1'b0, hbase_q} + IDX_W'(k_q);
  assign ops_inc    = {1'b0, ops_q} + 9'd1;
  assign tail_pend  = (mem_q.status == ST_PENDING);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    pay_d    = pay_q;
    force_d  = force_q;
    ok_d     = ok_q;
    pout_d   = pout_q;
    ckpt_d   = ckpt_q;
    head_d   = head_q;
    tail_d   = tail_q;
    hbase_d  = hbase_q;
    hoff_d   = hoff_q;
    pendt_d  = pendt_q;
    drop_d   = drop_q;
    nord_d   = nord_q;
    gen_d    = gen_q;
    ops_d    = ops_q;
    act_d    = act_q;
    ju_d     = ju_q;
    idx_d    = idx_q;
    sb_d     = sb_q;
    so_d     = so_q;
    psb_d    = psb_q;
    pso_d    = pso_q;
    k_d      = k_q;
    live_d   = 1'b0;
    pidx_d   = pidx_q;
    cur_d    = cur_q;
    any_d    = any_q;
    anyp_d   = anyp_q;
    maxo_d   = maxo_q;
    mino_d   = mino_q;
    maxs_d   = maxs_q;
    mins_d   = mins_q;
    maxb_d   = maxb_q;
    maxoff_d = maxoff_q;
    pend_d   = pend_q;
    out_d    = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    mem_we    = 1'b0;
    mem_waddr = head_q;
    mem_wdata = '0;
    rd_addr   = head_q;
    ckpt_do    = 1'b0;
    start_scan = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[SLOT_W-1:0];
        mem_wdata.status = ST_ERASED;
        idx_d = idx_q + IDX_W'(1);
        if (idx_q == IDX_W'(NUM_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_i.command;
          pay_d   = in_i.payload_in;
          force_d = in_i.force_checkpoint;
          ok_d    = 1'b1;
          pout_d  = '0;
          ckpt_d  = 1'b0;
          unique case (in_i.command)
            CMD_APPEND: begin
              rd_addr = head_q;
              state_d = S_HEAD;
            end
            CMD_PEEK, CMD_POP: begin
              rd_addr = tail_q;
              state_d = S_TAIL;
            end
            CMD_FLUSH: begin
              ckpt_do = 1'b1;
              ckpt_d  = 1'b1;
              state_d = S_FIN;
            end
            default: state_d = S_FIN;
          endcase
        end
      end

      S_HEAD: begin
        if (mem_q.status == ST_ERASED) begin
          state_d = S_WRITE;
        end else begin
          k_d     = '0;
          state_d = S_ERASE;
        end
      end

      S_ERASE: begin
        // read slot k, erase the slot read last cycle
        if (live_q) begin
          mem_we    = 1'b1;
          mem_waddr = pidx_q;
          mem_wdata.status = ST_ERASED;
          if (mem_q.status == ST_PENDING) begin
            drop_d = drop_q + 32'd1;
          end
        end
        if (k_q != K_W'(SLOTS_PER_SECTOR)) begin
          k_d = k_q + K_W'(1);
          if (erase_addr < IDX_W'(NUM_SLOTS)) begin
            rd_addr = erase_addr[SLOT_W-1:0];
            live_d  = 1'b1;
            pidx_d  = erase_addr[SLOT_W-1:0];
          end
        end else begin
          start_scan = 1'b1;
        end
      end

      S_SCAN: begin
        if (live_q && (mem_q.status != ST_ERASED)) begin
          if (!any_q || (mem_q.order >= maxo_q)) begin
            maxo_d   = mem_q.order;
            maxs_d   = pidx_q;
            maxb_d   = psb_q[SLOT_W-1:0];
            maxoff_d = pso_q;
          end
          if (mem_q.status == ST_PENDING) begin
            pend_d = pend_q + CNT_W'(1);
            if (!anyp_q || (mem_q.order < mino_q)) begin
              mino_d = mem_q.order;
              mins_d = pidx_q;
            end
            anyp_d = 1'b1;
          end
          any_d = 1'b1;
        end
        if (idx_q != IDX_W'(NUM_SLOTS)) begin
          rd_addr = idx_q[SLOT_W-1:0];
          live_d  = 1'b1;
          pidx_d  = idx_q[SLOT_W-1:0];
          psb_d   = sb_q;
          pso_d   = so_q;
          idx_d   = idx_q + IDX_W'(1);
          if (so_q == OFF_W'(SLOTS_PER_SECTOR - 1)) begin
            so_d = '0;
            sb_d = sb_q + IDX_W'(SLOTS_PER_SECTOR);
          end else begin
            so_d = so_q + OFF_W'(1);
          end
        end else begin
          state_d = S_RBEND;
        end
      end

      S_RBEND: begin
        pendt_d = pend_q;
        tail_d  = rb_tail;
        if (any_q) begin
          head_d  = mx_nxt;
          hbase_d = mx_nb;
          hoff_d  = mx_no;
          nord_d  = maxo_q + 32'd1;
        end else begin
          head_d  = '0;
          hbase_d = '0;
          hoff_d  = '0;
          nord_d  = 32'd1;
        end
        if (cmd_q == CMD_APPEND) begin
          state_d = S_WRITE;
        end else begin
          rd_addr = rb_tail;
          state_d = S_PEEK2;
        end
      end

      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = head_q;
        mem_wdata.status  = ST_PENDING;
        mem_wdata.order   = nord_q;
        mem_wdata.payload = pay_q;
        nord_d  = nord_q + 32'd1;
        head_d  = hd_nxt;
        hbase_d = hd_nb;
        hoff_d  = hd_no;
        pendt_d = pendt_q + CNT_W'(1);
        ops_d   = ops_q + 8'd1;
        if (force_q || (ops_inc >= {1'b0, intv_q})) begin
          ckpt_do = 1'b1;
          ckpt_d  = 1'b1;
        end
        state_d = S_FIN;
      end

      S_TAIL: begin
        if (cmd_q == CMD_PEEK) begin
          if (pendt_q == '0) begin
            ok_d    = 1'b0;
            state_d = S_FIN;
          end else if (tail_pend) begin
            pout_d  = mem_q.payload;
            state_d = S_FIN;
          end else begin
            start_scan = 1'b1;
          end
        end else begin
          if ((pendt_q == '0) || !tail_pend) begin
            ok_d    = 1'b0;
            state_d = S_FIN;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = tail_q;
            mem_wdata = mem_q;
            mem_wdata.status = ST_DELIVERED;
            pendt_d = pendt_q - CNT_W'(1);
            ops_d   = ops_q + 8'd1;
            if (ops_inc >= {1'b0, intv_q}) begin
              ckpt_do = 1'b1;
              ckpt_d  = 1'b1;
            end
            if (pendt_q != CNT_W'(1)) begin
              cur_d   = tail_q;
              idx_d   = '0;
              state_d = S_ADV;
            end else begin
              tail_d  = head_q;
              state_d = S_FIN;
            end
          end
        end
      end

      S_ADV: begin
        // walk forward one slot a cycle to the next pending record
        if (live_q && tail_pend) begin
          tail_d  = pidx_q;
          state_d = S_FIN;
        end else if (idx_q == IDX_W'(NUM_SLOTS)) begin
          pendt_d = '0;
          tail_d  = head_q;
          state_d = S_FIN;
        end else begin
          rd_addr = cur_nxt;
          cur_d   = cur_nxt;
          pidx_d  = cur_nxt;
          live_d  = 1'b1;
          idx_d   = idx_q + IDX_W'(1);
        end
      end

      S_PEEK2: begin
        ok_d    = (pendt_q != '0) && tail_pend;
        pout_d  = ((pendt_q != '0) && tail_pend) ? mem_q.payload : 64'd0;
        state_d = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.ok               = ok_q;
          out_d.payload_out      = pout_q;
          out_d.pending_count    = 11'(pendt_q);
          out_d.dropped_total    = drop_q;
          out_d.checkpoint_taken = ckpt_q;
          out_d.generation       = gen_q;
          out_d.header_sector    = act_q;
          out_d.header_entry     = (ju_q != '0) ? 6'(ju_q - JU_W'(1)) : 6'd0;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (start_scan) begin
      idx_d    = '0;
      sb_d     = '0;
      so_d     = '0;
      any_d    = 1'b0;
      anyp_d   = 1'b0;
      maxo_d   = '0;
      mino_d   = '0;
      maxs_d   = '0;
      mins_d   = '0;
      maxb_d   = '0;
      maxoff_d = '0;
      pend_d   = '0;
      live_d   = 1'b0;
      state_d  = S_SCAN;
    end

    // header journal: swap sectors when the active one is full
    if (ckpt_do) begin
      gen_d = gen_q + 32'd1;
      ops_d = '0;
      if (ju_q >= JU_W'(JOURNAL_ENTRIES)) begin
        act_d = ~act_q;
        ju_d  = JU_W'(1);
      end else begin
        ju_d  = ju_q + JU_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intv_q <= CKPT_INTERVAL_RST;
    end else if (cfg_we_i) begin
      intv_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      head_q      <= '0;
      tail_q      <= '0;
      hbase_q     <= '0;
      hoff_q      <= '0;
      pendt_q     <= '0;
      drop_q      <= '0;
      nord_q      <= 32'd1;
      gen_q       <= '0;
      ops_q       <= '0;
      act_q       <= 1'b0;
      ju_q        <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      live_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      hbase_q     <= hbase_d;
      hoff_q      <= hoff_d;
      pendt_q     <= pendt_d;
      drop_q      <= drop_d;
      nord_q      <= nord_d;
      gen_q       <= gen_d;
      ops_q       <= ops_d;
      act_q       <= act_d;
      ju_q        <= ju_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    pay_q    <= pay_d;
    force_q  <= force_d;
    ok_q     <= ok_d;
    pout_q   <= pout_d;
    ckpt_q   <= ckpt_d;
    sb_q     <= sb_d;
    so_q     <= so_d;
    psb_q    <= psb_d;
    pso_q    <= pso_d;
    pidx_q   <= pidx_d;
    cur_q    <= cur_d;
    any_q    <= any_d;
    anyp_q   <= anyp_d;
    maxo_q   <= maxo_d;
    mino_q   <= mino_d;
    maxs_q   <= maxs_d;
    mins_q   <= mins_d;
    maxb_q   <= maxb_d;
    maxoff_q <= maxoff_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("sequencer took a transfer but did not go busy");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pendt_q <= CNT_W'(NUM_SLOTS))
    else $error("pending count exceeds slot count");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && !(out_valid_q && out_stall_i)) |=> out_valid_q)
    else $error("finished command did not load the output register");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("slot memory written while idle");
`endif

endmodule

// ----- sv/frlq_slot_ram.sv -----
// Simple dual-port slot memory with registered read data.
module frlq_slot_ram #(
  parameter int unsigned DEPTH = frlq_pkg::NUM_SLOTS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  frlq_pkg::slot_t      wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output frlq_pkg::slot_t      rdata_o
);
  import frlq_pkg::*;

  slot_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
